### rtl/lifo_stack_with_search_core_defines.svh
// Assertion macros shared by the stack core modules.
`ifndef LIFO_STACK_WITH_SEARCH_CORE_DEFINES_SVH
`define LIFO_STACK_WITH_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, checked on every edge outside reset.
`define LSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every edge outside reset.
`define LSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/lss_pkg.sv
// Shared types and constants of the LIFO stack with search.
`timescale 1ns / 1ps

package lss_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WORD_W    = 32;
	localparam int POS_W     = 6;

	typedef enum logic [2:0] {
		OP_CLEAR_PUSH = 3'd0,
		OP_PUSH       = 3'd1,
		OP_POP        = 3'd2,
		OP_TRAVERSE   = 3'd3,
		OP_SEARCH     = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_EMPTY     = 3'd1,
		STS_FULL      = 3'd2,
		STS_FOUND     = 3'd3,
		STS_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_TRAV,
		ST_SRCH
	} state_t;

	// Which kind of result the datapath registers on an emit.
	typedef enum logic [2:0] {
		RK_PUSH,
		RK_FULL,
		RK_EMPTY,
		RK_MISS,
		RK_POP,
		RK_TRAV,
		RK_HIT
	} res_kind_t;

	typedef struct packed {
		logic      clear_push;
		logic      push;
		logic      pop;
		logic      walk_start;
		logic      walk_step;
		logic      emit;
		logic      emit_last;
		res_kind_t kind;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic walk_end;
		logic match;
	} stat_t;

endpackage

### rtl/lifo_stack_with_search_core.sv
// Top level of the LIFO stack with linear search.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------
//  command  | start in, busy out | op, value
//  result   | strobe out         | status, data, position, last
//
// Push and clear-and-push complete without leaving idle; busy stays low.
// Pop makes one RAM read; traverse visits every entry and search stops at a hit:
// the walk reads one entry per cycle through the single RAM read port.
// Reset clears the entry count and the controller; entry RAM is not cleared.
// The receiver cannot stall: each result is on the ports for one cycle only.
`timescale 1ns / 1ps

module lifo_stack_with_search_core #(
	parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [2:0]                        op,
	input  logic signed [lss_pkg::WORD_W-1:0] value,
	output logic                              strobe,
	output logic [2:0]                        status,
	output logic signed [lss_pkg::WORD_W-1:0] data,
	output logic [lss_pkg::POS_W-1:0]         position,
	output logic                              last
);

	lss_pkg::cmd_t  cmd;
	lss_pkg::stat_t stat;

	lss_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.op    (op),
		.stat  (stat),
		.busy  (busy),
		.cmd   (cmd)
	);

	lss_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.value   (value),
		.stat    (stat),
		.strobe  (strobe),
		.status  (status),
		.data    (data),
		.position(position),
		.last    (last)
	);

endmodule

### rtl/lss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lss_ram #(
	parameter int WIDTH = lss_pkg::WORD_W,
	parameter int DEPTH = lss_pkg::DEPTH_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/lss_ctrl.sv
// Controller state machine of the stack core: decodes ops and sequences walks.
`timescale 1ns / 1ps
`include "lifo_stack_with_search_core_defines.svh"

module lss_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [2:0]     op,
	input  lss_pkg::stat_t stat,
	output logic           busy,
	output lss_pkg::cmd_t  cmd
);

	lss_pkg::state_t state_q, state_d;
	lss_pkg::op_t    op_dec;

	assign op_dec = lss_pkg::op_t'(op);
	assign busy   = (state_q != lss_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lss_pkg::ST_IDLE: begin
				if (start) begin
					unique case (op_dec)
						lss_pkg::OP_POP:      if (!stat.empty) state_d = lss_pkg::ST_POP;
						lss_pkg::OP_TRAVERSE: if (!stat.empty) state_d = lss_pkg::ST_TRAV;
						lss_pkg::OP_SEARCH:   if (!stat.empty) state_d = lss_pkg::ST_SRCH;
						default:              state_d = lss_pkg::ST_IDLE;
					endcase
				end
			end
			lss_pkg::ST_POP: state_d = lss_pkg::ST_IDLE;
			lss_pkg::ST_TRAV: begin
				if (stat.walk_end) state_d = lss_pkg::ST_IDLE;
			end
			lss_pkg::ST_SRCH: begin
				if (stat.match || stat.walk_end) state_d = lss_pkg::ST_IDLE;
			end
			default: state_d = lss_pkg::ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			lss_pkg::ST_IDLE: begin
				if (start) begin
					unique case (op_dec)
						lss_pkg::OP_CLEAR_PUSH: begin
							cmd.clear_push = 1'b1;
							cmd.emit       = 1'b1;
							cmd.emit_last  = 1'b1;
							cmd.kind       = lss_pkg::RK_PUSH;
						end
						lss_pkg::OP_PUSH: begin
							cmd.push      = !stat.full;
							cmd.emit      = 1'b1;
							cmd.emit_last = 1'b1;
							cmd.kind      = stat.full ? lss_pkg::RK_FULL : lss_pkg::RK_PUSH;
						end
						lss_pkg::OP_POP: begin
							cmd.pop       = !stat.empty;
							cmd.emit      = stat.empty;
							cmd.emit_last = 1'b1;
							cmd.kind      = lss_pkg::RK_EMPTY;
						end
						lss_pkg::OP_TRAVERSE: begin
							cmd.walk_start = !stat.empty;
							cmd.emit       = stat.empty;
							cmd.emit_last  = 1'b1;
							cmd.kind       = lss_pkg::RK_EMPTY;
						end
						lss_pkg::OP_SEARCH: begin
							cmd.walk_start = !stat.empty;
							cmd.emit       = stat.empty;
							cmd.emit_last  = 1'b1;
							cmd.kind       = lss_pkg::RK_MISS;
						end
						default: cmd = '0;
					endcase
				end
			end
			lss_pkg::ST_POP: begin
				cmd.emit      = 1'b1;
				cmd.emit_last = 1'b1;
				cmd.kind      = lss_pkg::RK_POP;
			end
			lss_pkg::ST_TRAV: begin
				cmd.emit      = 1'b1;
				cmd.emit_last = stat.walk_end;
				cmd.kind      = lss_pkg::RK_TRAV;
				cmd.walk_step = !stat.walk_end;
			end
			lss_pkg::ST_SRCH: begin
				// report a hit first; a miss only once the bottom entry is checked
				cmd.emit      = stat.match || stat.walk_end;
				cmd.emit_last = 1'b1;
				cmd.kind      = stat.match ? lss_pkg::RK_HIT : lss_pkg::RK_MISS;
				cmd.walk_step = !stat.match && !stat.walk_end;
			end
			default: cmd = '0;
		endcase
	end

	`LSS_ASSERT_NEXT(a_pop_one_cycle, clk, arst_n, state_q == lss_pkg::ST_POP, state_q == lss_pkg::ST_IDLE, "pop state did not return to idle")
	`LSS_ASSERT_IMPLY(a_walk_emits_once, clk, arst_n, (state_q == lss_pkg::ST_TRAV) && stat.walk_end, cmd.emit && cmd.emit_last && !cmd.walk_step, "traverse end not marked last")

endmodule

### rtl/lss_dp.sv
// Datapath of the stack core: entry count, walk pointer, entry RAM and result registers.
`timescale 1ns / 1ps
`include "lifo_stack_with_search_core_defines.svh"

module lss_dp #(
	parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lss_pkg::cmd_t                       cmd,
	input  logic signed [lss_pkg::WORD_W-1:0]   value,
	output lss_pkg::stat_t                      stat,
	output logic                                strobe,
	output logic [2:0]                          status,
	output logic signed [lss_pkg::WORD_W-1:0]   data,
	output logic [lss_pkg::POS_W-1:0]           position,
	output logic                                last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     count_m1;
	logic [AW-1:0]                     ptr_q;
	logic [lss_pkg::POS_W-1:0]         idx_q;
	logic signed [lss_pkg::WORD_W-1:0] key_q;

	logic                              ram_we;
	logic [AW-1:0]                     ram_waddr;
	logic [AW-1:0]                     ram_raddr;
	logic [lss_pkg::WORD_W-1:0]        ram_rdata;

	logic                              strobe_q;
	lss_pkg::status_t                  status_q;
	logic signed [lss_pkg::WORD_W-1:0] data_q;
	logic [lss_pkg::POS_W-1:0]         position_q;
	logic                              last_q;

	assign count_m1 = count_q - CW'(1);

	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q == CW'(DEPTH));
	assign stat.walk_end = (ptr_q == '0);
	assign stat.match    = (ram_rdata == key_q);

	assign ram_we    = cmd.push || cmd.clear_push;
	assign ram_waddr = cmd.clear_push ? '0 : count_q[AW-1:0];

	// Top entry on pop or walk start, next lower entry on a walk step
	always_comb begin
		priority if (cmd.walk_step) begin
			ram_raddr = ptr_q - AW'(1);
		end else begin
			ram_raddr = count_m1[AW-1:0];
		end
	end

	lss_ram #(
		.WIDTH(lss_pkg::WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(value),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			priority if (cmd.clear_push) begin
				count_q <= CW'(1);
			end else if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop) begin
				count_q <= count_m1;
			end
			strobe_q <= cmd.emit;
		end
	end

	// Walk registers and result payload
	always_ff @(posedge clk) begin
		priority if (cmd.walk_start) begin
			ptr_q <= count_m1[AW-1:0];
			idx_q <= '0;
			key_q <= value;
		end else if (cmd.walk_step) begin
			ptr_q <= ptr_q - AW'(1);
			idx_q <= idx_q + lss_pkg::POS_W'(1);
		end
		if (cmd.emit) begin
			last_q <= cmd.emit_last;
			unique case (cmd.kind)
				lss_pkg::RK_PUSH: begin
					status_q   <= lss_pkg::STS_OK;
					data_q     <= value;
					position_q <= '0;
				end
				lss_pkg::RK_FULL: begin
					status_q   <= lss_pkg::STS_FULL;
					data_q     <= '0;
					position_q <= '0;
				end
				lss_pkg::RK_EMPTY: begin
					status_q   <= lss_pkg::STS_EMPTY;
					data_q     <= '0;
					position_q <= '0;
				end
				lss_pkg::RK_MISS: begin
					status_q   <= lss_pkg::STS_NOT_FOUND;
					data_q     <= '0;
					position_q <= '0;
				end
				lss_pkg::RK_POP: begin
					status_q   <= lss_pkg::STS_OK;
					data_q     <= ram_rdata;
					position_q <= '0;
				end
				lss_pkg::RK_TRAV: begin
					status_q   <= lss_pkg::STS_OK;
					data_q     <= ram_rdata;
					position_q <= idx_q;
				end
				lss_pkg::RK_HIT: begin
					status_q   <= lss_pkg::STS_FOUND;
					data_q     <= ram_rdata;
					position_q <= idx_q;
				end
				default: begin
					status_q   <= lss_pkg::STS_OK;
					data_q     <= '0;
					position_q <= '0;
				end
			endcase
		end
	end

	assign strobe   = strobe_q;
	assign status   = status_q;
	assign data     = data_q;
	assign position = position_q;
	assign last     = last_q;

	`LSS_ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH), "entry count above depth")
	`LSS_ASSERT_IMPLY(a_push_room, clk, arst_n, cmd.push, !stat.full, "push issued on a full stack")
	`LSS_ASSERT_IMPLY(a_step_in_range, clk, arst_n, cmd.walk_step, !stat.walk_end, "walk stepped past the bottom entry")

endmodule
